// ===== sv/evbs_pkg.sv =====
// Shared types and constants for the exhaust valve button sequencer.
package evbs_pkg;

   // Field widths
   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned RpmWidth    = 16;
   localparam int unsigned ReqWidth    = 2;
   localparam int unsigned StageWidth  = 3;
   localparam int unsigned IndexWidth  = 2;
   localparam int unsigned MsWidth     = 16;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrDatWidth = 16;

   // Register indexes on the csr port
   localparam logic [CsrIdxWidth-1:0] CSR_FEATURE_ENABLE   = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_PRESS_DURATION   = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_MESSAGE_INTERVAL = 2'd2;

   // Register reset values
   localparam logic [MsWidth-1:0] PRESS_DURATION_RESET   = 16'd1000;
   localparam logic [MsWidth-1:0] MESSAGE_INTERVAL_RESET = 16'd500;

   // Valve request codes (any other nonzero code presses close)
   localparam logic [ReqWidth-1:0] REQ_NONE = 2'd0;
   localparam logic [ReqWidth-1:0] REQ_OPEN = 2'd1;

   // Sequence stages
   localparam logic [StageWidth-1:0] STAGE_IDLE  = 3'd0;
   localparam logic [StageWidth-1:0] STAGE_FIRST = 3'd1;
   localparam logic [StageWidth-1:0] STAGE_TWO   = 3'd2;
   localparam logic [StageWidth-1:0] STAGE_THREE = 3'd3;
   localparam logic [StageWidth-1:0] STAGE_LAST  = 3'd4;

   // Configuration register set
   typedef struct packed {
      logic               feature_enable;
      logic [MsWidth-1:0] press_duration_ms;
      logic [MsWidth-1:0] message_interval_ms;
   } cfg_type;

   // One poll word
   typedef struct packed {
      logic [TimeWidth-1:0] now_ms;
      logic [RpmWidth-1:0]  engine_rpm;
      logic [ReqWidth-1:0]  valve_request;
      logic                 start_sequence;
   } poll_type;

   // One result word
   typedef struct packed {
      logic                  open_button;
      logic                  close_button;
      logic                  valve_is_open;
      logic                  message_send;
      logic [IndexWidth-1:0] message_index;
      logic [StageWidth-1:0] sequence_stage;
   } result_type;

endpackage

// ===== sv/exhaust_valve_button_sequencer.sv =====
// Top level: config registers, input register, result register around the step logic.
//
//  channel  ports          direction  word
//  req      req_*          in         one poll: time, rpm, request, start flag
//  rsp      rsp_*          out        one result: buttons, valve, message, stage
//  csr      csr_*          in         register write: enable, duration, interval
//
// One poll per clock sustained while rsp is not stalled; an accepted poll passes
// the input register, then the result register, and the result word is set by the
// single combinational pass of the step logic between them.
// Reset clears all control state and loads the register defaults.
// A stall on rsp holds the result; the input register keeps taking a poll
// as long as its word can move on, so req_stall rises only when both are full.
module exhaust_valve_button_sequencer (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [evbs_pkg::TimeWidth-1:0]      req_now_ms,
   input  logic [evbs_pkg::RpmWidth-1:0]       req_engine_rpm,
   input  logic [evbs_pkg::ReqWidth-1:0]       req_valve_request,
   input  logic                                req_start_sequence,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_open_button,
   output logic                                rsp_close_button,
   output logic                                rsp_valve_is_open,
   output logic                                rsp_message_send,
   output logic [evbs_pkg::IndexWidth-1:0]     rsp_message_index,
   output logic [evbs_pkg::StageWidth-1:0]     rsp_sequence_stage,

   input  logic                                csr_write_enable,
   input  logic [evbs_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [evbs_pkg::CsrDatWidth-1:0]    csr_write_data
);

   evbs_pkg::cfg_type     cfg_ff;
   evbs_pkg::poll_type    poll_ff;
   logic                  poll_valid_ff;
   evbs_pkg::result_type  result_ff;
   evbs_pkg::result_type  result;
   logic                  rsp_valid_ff;
   logic                  advance;
   logic                  req_take;

   // Move the polled word on when the result register is free or draining
   assign advance   = poll_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = poll_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.feature_enable      <= 1'b0;
         cfg_ff.press_duration_ms   <= evbs_pkg::PRESS_DURATION_RESET;
         cfg_ff.message_interval_ms <= evbs_pkg::MESSAGE_INTERVAL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            evbs_pkg::CSR_FEATURE_ENABLE:   cfg_ff.feature_enable <= csr_write_data[0];
            evbs_pkg::CSR_PRESS_DURATION:   cfg_ff.press_duration_ms <= csr_write_data;
            evbs_pkg::CSR_MESSAGE_INTERVAL: cfg_ff.message_interval_ms <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Input register: hold the poll until it moves to the result
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
      end else if (req_take) begin
         poll_valid_ff <= 1'b1;
      end else if (advance) begin
         poll_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         poll_ff.now_ms         <= req_now_ms;
         poll_ff.engine_rpm     <= req_engine_rpm;
         poll_ff.valve_request  <= req_valve_request;
         poll_ff.start_sequence <= req_start_sequence;
      end
   end

   evbs_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .cfg     (cfg_ff),
      .poll    (poll_ff),
      .result  (result)
   );

   // Result register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_open_button    = result_ff.open_button;
   assign rsp_close_button   = result_ff.close_button;
   assign rsp_valve_is_open  = result_ff.valve_is_open;
   assign rsp_message_send   = result_ff.message_send;
   assign rsp_message_index  = result_ff.message_index;
   assign rsp_sequence_stage = result_ff.sequence_stage;

endmodule

// ===== sv/evbs_step.sv =====
// Controller state and the combinational update logic for one poll.
module evbs_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  evbs_pkg::cfg_type     cfg,
   input  evbs_pkg::poll_type    poll,
   output evbs_pkg::result_type  result
);

   logic                                open_drive_ff,     open_drive_in;
   logic                                close_drive_ff,    close_drive_in;
   logic                                press_pending_ff,  press_pending_in;
   logic [evbs_pkg::TimeWidth-1:0]      press_start_ff,    press_start_in;
   logic                                valve_open_ff,     valve_open_in;
   logic [evbs_pkg::StageWidth-1:0]     stage_ff,          stage_in;
   logic [evbs_pkg::TimeWidth-1:0]      last_msg_ff,       last_msg_in;

   logic [evbs_pkg::TimeWidth-1:0]      press_elapsed;
   logic [evbs_pkg::TimeWidth-1:0]      msg_elapsed;
   logic                                rpm_zero;
   logic [evbs_pkg::StageWidth-1:0]     stage_start;
   logic [evbs_pkg::StageWidth-1:0]     stage_sent;
   logic                                send;
   logic [evbs_pkg::IndexWidth-1:0]     index;

   assign press_elapsed = poll.now_ms - press_start_ff;
   assign msg_elapsed   = poll.now_ms - last_msg_ff;
   assign rpm_zero      = (poll.engine_rpm == '0);

   // Work out the next state for the poll in the input register
   always_comb begin
      open_drive_in    = open_drive_ff;
      close_drive_in   = close_drive_ff;
      press_pending_in = press_pending_ff;
      press_start_in   = press_start_ff;
      valve_open_in    = valve_open_ff;
      stage_in         = stage_ff;
      last_msg_in      = last_msg_ff;
      stage_start      = stage_ff;
      stage_sent       = stage_ff;
      send             = 1'b0;
      index            = '0;

      if (cfg.feature_enable) begin
         if (poll.start_sequence) begin
            stage_start = evbs_pkg::STAGE_FIRST;
         end
         stage_in = stage_start;

         // Release both buttons once the press time has run out
         if (press_pending_ff &&
             (press_elapsed > {{(evbs_pkg::TimeWidth-evbs_pkg::MsWidth){1'b0}},
                               cfg.press_duration_ms})) begin
            open_drive_in    = 1'b0;
            close_drive_in   = 1'b0;
            press_pending_in = 1'b0;
         end

         // Press the requested button and record the valve position
         if (poll.valve_request != evbs_pkg::REQ_NONE) begin
            if (poll.valve_request == evbs_pkg::REQ_OPEN) begin
               open_drive_in = 1'b1;
            end else begin
               close_drive_in = 1'b1;
            end
            valve_open_in    = (poll.valve_request == evbs_pkg::REQ_OPEN);
            press_start_in   = poll.now_ms;
            press_pending_in = 1'b1;
         end

         // Close automatically when the engine has stopped
         if (valve_open_in && rpm_zero) begin
            close_drive_in   = 1'b1;
            press_start_in   = poll.now_ms;
            press_pending_in = 1'b1;
            valve_open_in    = 1'b0;
         end

         // Advance the message sequence once the interval has passed
         if ((stage_start inside {[evbs_pkg::STAGE_FIRST:evbs_pkg::STAGE_LAST]}) &&
             (msg_elapsed > {{(evbs_pkg::TimeWidth-evbs_pkg::MsWidth){1'b0}},
                             cfg.message_interval_ms})) begin
            stage_sent  = rpm_zero ? evbs_pkg::STAGE_LAST : stage_start;
            send        = 1'b1;
            index       = evbs_pkg::IndexWidth'(stage_sent - evbs_pkg::STAGE_FIRST);
            last_msg_in = poll.now_ms;
            case (stage_sent)
               evbs_pkg::STAGE_FIRST: stage_in = evbs_pkg::STAGE_TWO;
               evbs_pkg::STAGE_TWO:   stage_in = evbs_pkg::STAGE_THREE;
               evbs_pkg::STAGE_THREE: stage_in = evbs_pkg::STAGE_TWO;
               default:               stage_in = evbs_pkg::STAGE_IDLE;
            endcase
         end
      end
   end

   // Result word for this poll
   always_comb begin
      result.open_button    = open_drive_in;
      result.close_button   = close_drive_in;
      result.valve_is_open  = valve_open_in;
      result.message_send   = send;
      result.message_index  = index;
      result.sequence_stage = stage_in;
   end

   // Commit the state when the poll moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         open_drive_ff    <= 1'b0;
         close_drive_ff   <= 1'b0;
         press_pending_ff <= 1'b0;
         press_start_ff   <= '0;
         valve_open_ff    <= 1'b0;
         stage_ff         <= evbs_pkg::STAGE_IDLE;
         last_msg_ff      <= '0;
      end else if (step_en) begin
         open_drive_ff    <= open_drive_in;
         close_drive_ff   <= close_drive_in;
         press_pending_ff <= press_pending_in;
         press_start_ff   <= press_start_in;
         valve_open_ff    <= valve_open_in;
         stage_ff         <= stage_in;
         last_msg_ff      <= last_msg_in;
      end
   end

endmodule
